// ===== rtl/vau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types and codes for the vertex attribute unpack unit.
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam logic [2:0] KIND_SINT  = 3'd0;
	localparam logic [2:0] KIND_UINT  = 3'd1;
	localparam logic [2:0] KIND_UNORM = 3'd2;
	localparam logic [2:0] KIND_SNORM = 3'd3;
	localparam logic [2:0] KIND_FLOAT = 3'd4;

	localparam logic [1:0] BITS_8  = 2'd0;
	localparam logic [1:0] BITS_16 = 2'd1;
	localparam logic [1:0] BITS_32 = 2'd2;

	localparam logic       OP_INT   = 1'b0;
	localparam logic       OP_FLOAT = 1'b1;

	localparam int unsigned LANES = 4;

	localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
	localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;

	// per-lane control, decoded once for the item
	typedef struct packed {
		logic       op;
		logic [2:0] kind;
		logic [1:0] wcode;
		logic       fill;
		logic       ok;
		logic       used;
	} lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/vertex_attribute_unpack_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_attribute_unpack_unit
// Unpacks one vertex attribute of up to 128 bits into four 32-bit channels.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input is registered in the lane register, then in the
//   output register, where the result becomes valid.
// Throughput: one item per cycle; four lanes convert the channels in parallel
//   and the pipeline only stalls when the output side holds tready low.
// Reset: arst_n clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module vertex_attribute_unpack_unit
	import vau_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [0] opcode, [3:1] element_kind, [5:4] element_bits, [8:6] channel_count,
	// [72:9] data_low, [136:73] data_high, [137] fill_minus_one, rest zero
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] channel_x, [63:32] channel_y, [95:64] channel_z,
	// [127:96] channel_w, [128] format_error, rest zero
	output logic      [135:0] m_axis_tdata
);

	logic         op;
	logic [2:0]   kind;
	logic [1:0]   wcode;
	logic [2:0]   count;
	logic [127:0] data;
	logic         fill;
	logic         ok;
	logic         en;
	logic         valid_s1;
	logic         err_s1;
	logic [31:0]  chan_s1 [LANES];

	assign op    = s_axis_tdata[0];
	assign kind  = s_axis_tdata[3:1];
	assign wcode = s_axis_tdata[5:4];
	assign count = s_axis_tdata[8:6];
	assign data  = s_axis_tdata[136:9];
	assign fill  = s_axis_tdata[137];

	// Format check: counts 1, 2, 4 everywhere, 3 only for 32-bit elements.
	// Integer path takes sint/uint at any width and unorm at 8 bits; float
	// path takes unorm/snorm at 8 or 16 bits and float at 16 or 32 bits.
	always_comb begin
		ok = (wcode != 2'd3) &&
			(count == 3'd1 || count == 3'd2 || count == 3'd4 ||
			(count == 3'd3 && wcode == BITS_32));
		if (op == OP_INT) begin
			ok = ok && (kind == KIND_SINT || kind == KIND_UINT ||
				(kind == KIND_UNORM && wcode == BITS_8));
		end else begin
			if (kind == KIND_UNORM || kind == KIND_SNORM) begin
				ok = ok && (wcode == BITS_8 || wcode == BITS_16) && (count != 3'd3);
			end else if (kind == KIND_FLOAT) begin
				ok = ok && (wcode == BITS_16 || wcode == BITS_32);
			end else begin
				ok = 1'b0;
			end
		end
	end

	// whole pipeline advances together; stalls only on a held output item
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= !ok;
		end
	end

	// lane i reads its channel at bit i*width
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lane_ctl_t   ctl;
		logic [31:0] raw;
		always_comb begin
			ctl.op    = op;
			ctl.kind  = kind;
			ctl.wcode = wcode;
			ctl.fill  = fill;
			ctl.ok    = ok;
			ctl.used  = (count > 3'(i));
			if (wcode == BITS_8) begin
				raw = {24'd0, data[i*8 +: 8]};
			end else if (wcode == BITS_16) begin
				raw = {16'd0, data[i*16 +: 16]};
			end else begin
				raw = data[i*32 +: 32];
			end
		end
		vau_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl     (ctl),
			.raw     (raw),
			.chan_s1 (chan_s1[i])
		);
	end

	vau_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.err_s1   (err_s1),
		.chan_s1  (chan_s1),
		.valid_q  (m_axis_tvalid),
		.data_q   (m_axis_tdata)
	);

	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[143:138];

endmodule
`default_nettype wire

// ===== rtl/vau_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vau_lane
// One channel converter: integer extend, normalized-to-float, half widen.
// ----------------------------------------------------------------------------
module vau_lane
	import vau_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire lane_ctl_t   ctl,
	input  wire logic [31:0] raw,
	output logic      [31:0] chan_s1
);

	logic        w8, w16;
	logic [31:0] r;
	logic [31:0] int_v;
	logic [31:0] half_v;
	logic [31:0] norm_v;
	logic [31:0] flt_v;
	logic [31:0] res;

	// integer path
	always_comb begin
		w8  = (ctl.wcode == BITS_8);
		w16 = (ctl.wcode == BITS_16);
		if (w8) begin
			r = {24'd0, raw[7:0]};
		end else if (w16) begin
			r = {16'd0, raw[15:0]};
		end else begin
			r = raw;
		end
		int_v = r;
		if (ctl.kind == KIND_SINT && w8 && raw[7]) begin
			int_v = {24'hFF_FFFF, raw[7:0]};
		end else if (ctl.kind == KIND_SINT && w16 && raw[15]) begin
			int_v = {16'hFFFF, raw[15:0]};
		end
	end

	// half to single widening
	logic [4:0]  he;
	logic [9:0]  hm;
	logic [3:0]  hs;
	logic [10:0] hn;
	always_comb begin
		he = raw[14:10];
		hm = raw[9:0];
		hs = 4'd0;
		for (int k = 0; k < 10; k++) begin
			if (hm[k]) begin
				hs = 4'(10 - k);
			end
		end
		hn = {1'b0, hm} << hs;
		if (he == 5'h1F) begin
			half_v = {raw[15], 8'hFF, hm, 13'd0};
		end else if (he == 5'd0) begin
			if (hm == 10'd0) begin
				half_v = {raw[15], 31'd0};
			end else begin
				half_v = {raw[15], 8'(8'd113 - {4'd0, hs}), hn[9:0], 13'd0};
			end
		end else begin
			half_v = {raw[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
		end
	end

	// x / (2^n - 1) is the n-bit pattern of x repeated forever after the
	// binary point, so the quotient is a repeat, a normalize shift and a
	// round-up on the guard bit (the tail below it is never all zero).
	logic        neg;
	logic [15:0] mag;
	logic [15:0] full;
	logic [15:0] mag_top;
	logic [3:0]  lz;
	logic [63:0] stream;
	logic [63:0] sh;
	logic [31:0] packed_v;
	always_comb begin
		neg = 1'b0;
		if (ctl.kind == KIND_SNORM) begin
			if (w8) begin
				neg  = raw[7];
				mag  = raw[7] ? 16'(9'h100 - {1'b0, raw[7:0]}) : {8'd0, raw[7:0]};
				full = 16'd127;
				mag_top = {mag[6:0], 9'd0};
				stream  = {{9{mag[6:0]}}, 1'b0};
			end else begin
				neg  = raw[15];
				mag  = raw[15] ? 16'(17'h10000 - {1'b0, raw[15:0]}) : raw[15:0];
				full = 16'd32767;
				mag_top = {mag[14:0], 1'b0};
				stream  = {{4{mag[14:0]}}, 4'd0};
			end
		end else begin
			if (w8) begin
				mag  = {8'd0, raw[7:0]};
				full = 16'd255;
				mag_top = {mag[7:0], 8'd0};
				stream  = {8{mag[7:0]}};
			end else begin
				mag  = raw[15:0];
				full = 16'd65535;
				mag_top = mag;
				stream  = {4{mag}};
			end
		end
		lz = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (mag_top[k]) begin
				lz = 4'(15 - k);
			end
		end
		sh = stream << lz;
		packed_v = {neg, 8'(8'd126 - {4'd0, lz}), sh[62:40]};
		if (mag == 16'd0) begin
			norm_v = 32'd0;
		end else if (mag >= full) begin
			norm_v = neg ? F32_NEG_ONE : F32_ONE;
		end else begin
			norm_v = packed_v + {31'd0, sh[39]};
		end
	end

	always_comb begin
		if (ctl.kind == KIND_FLOAT) begin
			flt_v = w16 ? half_v : raw;
		end else begin
			flt_v = norm_v;
		end
		if (!ctl.ok) begin
			res = 32'd0;
		end else if (!ctl.used) begin
			res = (ctl.op == OP_INT && ctl.fill) ? 32'hFFFF_FFFF : 32'd0;
		end else begin
			res = (ctl.op == OP_INT) ? int_v : flt_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s1 <= res;
		end
	end

	logic unused_rst;
	assign unused_rst = arst_n;

endmodule
`default_nettype wire

// ===== rtl/vau_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vau_merge
// Joins the lane results and the error flag into the output register.
// ----------------------------------------------------------------------------
module vau_merge
	import vau_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         valid_s1,
	input  wire logic         err_s1,
	input  wire logic [31:0]  chan_s1 [LANES],
	output logic              valid_q,
	output logic      [135:0] data_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {7'd0, err_s1, chan_s1[3], chan_s1[2], chan_s1[1], chan_s1[0]};
		end
	end

endmodule
`default_nettype wire

// ===== tb/vertex_attribute_unpack_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_attribute_unpack_unit_tb
// Drives vertex attributes into the unpack unit and checks every channel and
// the error flag against an in-bench model of the unpacker. A directed table
// of corner cases runs first, then random attributes, with random idle bursts
// on both stream sides.
// ----------------------------------------------------------------------------
module vertex_attribute_unpack_unit_tb;
	import vau_pkg::*;

	localparam int N_RANDOM  = 1250;
	localparam int WDOG_MAX  = 2000;
	localparam int N_DIRECTED = 17;

	typedef struct {
		logic        op;
		logic [2:0]  kind;
		logic [1:0]  wcode;
		logic [2:0]  count;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        fill;
	} attr_t;

	typedef struct {
		logic [31:0] ch [LANES];
		logic        err;
	} unpacked_t;

	typedef struct {
		attr_t     a;
		bit        typed;
		unpacked_t r;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;

	unpacked_t expected_channels [$];
	int        mismatches;
	int        idle_cycles;
	bit        quiet;
	row_t      rows [N_DIRECTED];

	vertex_attribute_unpack_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// correctly rounded num/den as float32, num > 0; 2^40 scale keeps 24+ bits
	function automatic logic [31:0] div_to_f32(logic sgn, logic [63:0] num,
			logic [63:0] den);
		logic [63:0] q, rem, low, half, m;
		int p;
		q = (num << 40) / den;
		rem = (num << 40) % den;
		p = 63;
		while (!q[p])
			p--;
		m = q >> (p - 23);
		low = q & ((64'd1 << (p - 23)) - 1);
		half = 64'd1 << (p - 24);
		if (low > half || (low == half && (rem != 0 || m[0])))
			m++;
		if (m[24]) begin
			m = m >> 1;
			p++;
		end
		return {sgn, 8'(p - 40 + 127), m[22:0]};
	endfunction

	function automatic logic [31:0] half_to_f32(logic [15:0] h);
		logic [31:0] sgn;
		logic [7:0]  ex;
		logic [9:0]  m;
		sgn = {h[15], 31'd0};
		m = h[9:0];
		if (h[14:10] == 5'h1F)
			return sgn | 32'h7F80_0000 | {9'd0, m, 13'd0};
		if (h[14:10] == 5'd0) begin
			if (m == 0)
				return sgn;
			ex = 8'd113;
			while (!m[9]) begin
				m = m << 1;
				ex--;
			end
			// one more shift moves the leading one out of the field
			m = m << 1;
			ex--;
			return sgn | {1'b0, ex, m, 13'd0};
		end
		return sgn | {1'b0, 8'(h[14:10] + 8'd112), m, 13'd0};
	endfunction

	function automatic unpacked_t unpack_attribute(attr_t a);
		unpacked_t   r;
		logic [127:0] bytes;
		logic [31:0] raw;
		int          w, sv;
		bit          ok;
		bytes = {a.hi, a.lo};
		w = (a.wcode == BITS_8) ? 8 : (a.wcode == BITS_16) ? 16 : 32;
		ok = a.wcode <= BITS_32 && (a.count == 1 || a.count == 2 || a.count == 4 ||
			(a.count == 3 && a.wcode == BITS_32));
		if (a.op == OP_INT)
			ok = ok && (a.kind == KIND_SINT || a.kind == KIND_UINT ||
				(a.kind == KIND_UNORM && a.wcode == BITS_8));
		else begin
			if (a.kind == KIND_UNORM || a.kind == KIND_SNORM)
				ok = ok && a.wcode <= BITS_16;
			else if (a.kind == KIND_FLOAT)
				ok = ok && (a.wcode == BITS_16 || a.wcode == BITS_32);
			else
				ok = 0;
			if (a.count == 3 && a.kind != KIND_FLOAT)
				ok = 0;
		end
		r.err = !ok;
		for (int i = 0; i < LANES; i++) begin
			r.ch[i] = 32'd0;
			if (!ok)
				continue;
			if (i >= a.count) begin
				r.ch[i] = (a.op == OP_INT && a.fill) ? 32'hFFFF_FFFF : 32'd0;
				continue;
			end
			raw = 32'(bytes >> (i * w));
			if (w < 32)
				raw = raw & ((32'd1 << w) - 1);
			if (a.op == OP_INT) begin
				r.ch[i] = raw;
				if (a.kind == KIND_SINT && w < 32 && raw[w-1])
					r.ch[i] = raw | (32'hFFFF_FFFF << w);
			end else if (a.kind == KIND_UNORM) begin
				r.ch[i] = (raw == 0) ? 32'd0 :
					div_to_f32(1'b0, 64'(raw), (w == 8) ? 64'd255 : 64'd65535);
			end else if (a.kind == KIND_SNORM) begin
				sv = raw[w-1] ? int'(raw) - (1 << w) : int'(raw);
				// most negative code clamps to -1
				if (sv == 0)
					r.ch[i] = 32'd0;
				else if (sv <= -((1 << (w - 1)) - 1))
					r.ch[i] = F32_NEG_ONE;
				else
					r.ch[i] = div_to_f32(sv < 0, 64'(sv < 0 ? -sv : sv),
						(w == 8) ? 64'd127 : 64'd32767);
			end else if (w == 16)
				r.ch[i] = half_to_f32(raw[15:0]);
			else
				r.ch[i] = raw;
		end
		return r;
	endfunction

	function automatic bit same_result(unpacked_t x, unpacked_t y);
		bit eq;
		eq = (x.err === y.err);
		for (int i = 0; i < LANES; i++)
			if (x.ch[i] !== y.ch[i])
				eq = 1'b0;
		return eq;
	endfunction

	function automatic attr_t mk(logic op, logic [2:0] kind, logic [1:0] wcode,
			logic [2:0] count, logic [63:0] lo, logic [63:0] hi, logic fill);
		attr_t a;
		a.op = op; a.kind = kind; a.wcode = wcode; a.count = count;
		a.lo = lo; a.hi = hi; a.fill = fill;
		return a;
	endfunction

	function automatic unpacked_t res(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] wv, logic err);
		unpacked_t r;
		r.ch[0] = x; r.ch[1] = y; r.ch[2] = z; r.ch[3] = wv; r.err = err;
		return r;
	endfunction

	// random attribute, mostly well-formed formats with random payload
	function automatic attr_t random_attr();
		attr_t a;
		int    pick;
		a = mk(1'($urandom_range(0, 1)), 3'($urandom), 2'($urandom), 3'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 9);
		if (pick < 8) begin
			if (a.op == OP_INT) begin
				a.kind = 3'($urandom_range(0, 2));
				a.wcode = (a.kind == KIND_UNORM) ? BITS_8 : 2'($urandom_range(0, 2));
			end else begin
				a.kind = 3'($urandom_range(2, 4));
				a.wcode = (a.kind == KIND_FLOAT) ? 2'($urandom_range(1, 2)) :
					2'($urandom_range(0, 1));
			end
			case ($urandom_range(0, 3))
				0: a.count = 3'd1;
				1: a.count = 3'd2;
				2: a.count = 3'd4;
				default: a.count = (a.wcode == BITS_32) ? 3'd3 : 3'd4;
			endcase
		end
		return a;
	endfunction

	task automatic send_attr(attr_t a);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, a.fill, a.hi, a.lo, a.count, a.wcode, a.kind, a.op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	// expectations are queued from the accepted input stream
	always @(posedge clk)
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			attr_t a;
			a = mk(s_axis_tdata[0], s_axis_tdata[3:1], s_axis_tdata[5:4],
				s_axis_tdata[8:6], s_axis_tdata[72:9], s_axis_tdata[136:73],
				s_axis_tdata[137]);
			expected_channels.push_back(unpack_attribute(a));
		end

	// output side stalls in bursts
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1)
					@(posedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			unpacked_t e, got;
			got = res(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tdata[127:96], m_axis_tdata[128]);
			if (expected_channels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", m_axis_tdata);
			end else begin
				e = expected_channels.pop_front();
				for (int i = 0; i < LANES; i++)
					if (got.ch[i] !== e.ch[i]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("channel %0d: expected %h, got %h", i, e.ch[i],
								got.ch[i]);
					end
				if (got.err !== e.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("format_error: expected %b, got %b", e.err, got.err);
				end
			end
		end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk)
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= WDOG_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;

	initial begin
		attr_t a;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;

		// integer path: sign extension extremes, fill, lane placement
		rows[0] = '{mk(OP_INT, KIND_SINT, BITS_8, 3'd4, 64'h807F_01FF, '0, 1'b0), 1'b1,
			res(32'hFFFF_FFFF, 32'h1, 32'h7F, 32'hFFFF_FF80, 1'b0)};
		rows[1] = '{mk(OP_INT, KIND_UINT, BITS_16, 3'd2, 64'hFFFF_0000, '0, 1'b1), 1'b1,
			res('0, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0)};
		rows[2] = '{mk(OP_INT, KIND_UINT, BITS_32, 3'd3, 64'hDEAD_BEEF_1234_5678,
			64'hFFFF_FFFF_CAFE_F00D, 1'b0), 1'b1,
			res(32'h1234_5678, 32'hDEAD_BEEF, 32'hCAFE_F00D, '0, 1'b0)};
		rows[3] = '{mk(OP_INT, KIND_UNORM, BITS_8, 3'd1, 64'hFF, '0, 1'b1), 1'b1,
			res(32'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0)};
		rows[4] = '{mk(OP_INT, KIND_SINT, BITS_32, 3'd4, '1, '1, 1'b1), 1'b1,
			res('1, '1, '1, '1, 1'b0)};
		// unsupported formats
		rows[5] = '{mk(OP_INT, 3'd7, BITS_8, 3'd4, '1, '1, 1'b1), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		rows[6] = '{mk(OP_INT, KIND_UINT, 2'd3, 3'd1, '1, '1, 1'b1), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		rows[7] = '{mk(OP_FLOAT, KIND_FLOAT, BITS_32, 3'd0, '1, '1, 1'b0), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		rows[8] = '{mk(OP_INT, KIND_UINT, BITS_16, 3'd3, '1, '1, 1'b0), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		rows[9] = '{mk(OP_FLOAT, KIND_SINT, BITS_8, 3'd1, '1, '1, 1'b0), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		rows[10] = '{mk(OP_FLOAT, KIND_UNORM, BITS_8, 3'd7, '1, '1, 1'b0), 1'b1,
			res('0, '0, '0, '0, 1'b1)};
		// float path: full scale, snorm clamp, half specials
		rows[11] = '{mk(OP_FLOAT, KIND_UNORM, BITS_8, 3'd1, 64'hFF, '0, 1'b1), 1'b1,
			res(F32_ONE, '0, '0, '0, 1'b0)};
		rows[12] = '{mk(OP_FLOAT, KIND_SNORM, BITS_8, 3'd2, 64'h7F80, '0, 1'b0), 1'b1,
			res(F32_NEG_ONE, F32_ONE, '0, '0, 1'b0)};
		rows[13] = '{mk(OP_FLOAT, KIND_SNORM, BITS_16, 3'd2, 64'h8001_8000, '0, 1'b0),
			1'b1, res(F32_NEG_ONE, F32_NEG_ONE, '0, '0, 1'b0)};
		rows[14] = '{mk(OP_FLOAT, KIND_FLOAT, BITS_16, 3'd4, 64'h7C00_0001_FC00_7E00,
			'0, 1'b1), 1'b1, res(32'h7FC0_0000, 32'hFF80_0000, 32'h3380_0000,
			32'h7F80_0000, 1'b0)};
		rows[15] = '{mk(OP_FLOAT, KIND_UNORM, BITS_16, 3'd4, 64'h0001_8000_7FFF_1234,
			'0, 1'b0), 1'b0, res('0, '0, '0, '0, 1'b0)};
		rows[16] = '{mk(OP_FLOAT, KIND_FLOAT, BITS_32, 3'd3, 64'h8000_0000_7F80_0001,
			64'h3F80_0000, 1'b0), 1'b0, res('0, '0, '0, '0, 1'b0)};

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			// typed rows double-check the predictor itself
			if (rows[i].typed && !same_result(unpack_attribute(rows[i].a), rows[i].r))
			begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: model disagrees with table", i);
			end
			send_attr(rows[i].a);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 200)
				quiet = 1;
			a = random_attr();
			send_attr(a);
		end
		s_axis_tvalid <= 1'b0;

		while (expected_channels.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/vau_pkg.sv
rtl/vau_lane.sv
rtl/vau_merge.sv
rtl/vertex_attribute_unpack_unit.sv
tb/vertex_attribute_unpack_unit_tb.sv
